>>> rtl/core/h3fd_pkg.sv
// Shared types for the HTTP/3 frame deframer: result kinds and the result record.
// No dependencies; used by every module in rtl/core.
`timescale 1ns / 1ps

package h3fd_pkg;

  localparam int unsigned VarintW  = 62;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned VlenW    = 3;
  localparam int unsigned QueueDepth = 4;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_DONE    = 2'd2,
    KIND_ERROR   = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e               kind;
    logic [VarintW-1:0]  frame_kind;
    logic [ByteW-1:0]    payload_byte;
    logic                frame_end;
    logic                run_last;
  } res_t;

  // Results produced by one byte: count (0..2), first result, second result.
  typedef struct packed {
    logic [1:0] num;
    res_t       r0;
    res_t       r1;
  } pres_t;

endpackage

>>> rtl/core/h3fd_parse.sv
// Frame parser state and per-byte decode: varint assembly, payload countdown, end check.
// Depends on h3fd_pkg.
`timescale 1ns / 1ps

module h3fd_parse (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic [h3fd_pkg::ByteW-1:0] byte_i,
  input  logic                       end_i,
  output h3fd_pkg::pres_t            res_o
);

  typedef enum logic [1:0] {
    PH_TYPE = 2'd0,
    PH_LEN  = 2'd1,
    PH_PAY  = 2'd2
  } phase_e;

  phase_e                            phase_q, phase_d;
  logic [h3fd_pkg::VlenW-1:0]        vleft_q, vleft_d;
  logic [h3fd_pkg::VarintW-1:0]      acc_q, acc_d;
  logic [h3fd_pkg::VarintW-1:0]      type_q, type_d;
  logic [h3fd_pkg::VarintW-1:0]      left_q, left_d;

  logic [h3fd_pkg::VarintW-1:0]      acc_n;
  logic [h3fd_pkg::VarintW-1:0]      left_dec;
  logic [h3fd_pkg::VlenW-1:0]        vleft_n;
  logic                              has_a;
  h3fd_pkg::res_t                    res_a;
  h3fd_pkg::res_t                    res_e;
  logic                              ok;

  always_comb begin
    phase_d  = phase_q;
    vleft_d  = vleft_q;
    acc_d    = acc_q;
    type_d   = type_q;
    left_d   = left_q;
    acc_n    = '0;
    vleft_n  = '0;
    left_dec = left_q - h3fd_pkg::VarintW'(1);
    has_a    = 1'b0;
    res_a    = '0;
    res_e    = '0;
    ok       = 1'b0;

    if (phase_q == PH_PAY) begin
      left_d             = left_dec;
      has_a              = 1'b1;
      res_a.kind         = h3fd_pkg::KIND_PAYLOAD;
      res_a.frame_kind   = type_q;
      res_a.payload_byte = byte_i;
      res_a.frame_end    = (left_dec == '0);
      if (left_dec == '0) begin
        phase_d = PH_TYPE;
      end
    end else begin
      if (vleft_q == '0) begin
        acc_n = {{(h3fd_pkg::VarintW-6){1'b0}}, byte_i[5:0]};
        // prefix 00/01/10/11 -> 1/2/4/8 bytes total
        case (byte_i[7:6])
          2'd0:    vleft_n = 3'd0;
          2'd1:    vleft_n = 3'd1;
          2'd2:    vleft_n = 3'd3;
          default: vleft_n = 3'd7;
        endcase
      end else begin
        acc_n   = {acc_q[h3fd_pkg::VarintW-9:0], byte_i};
        vleft_n = vleft_q - 3'd1;
      end
      vleft_d = vleft_n;
      acc_d   = acc_n;
      if (vleft_n == '0) begin
        acc_d = '0;
        if (phase_q == PH_LEN) begin
          left_d = acc_n;
          if (acc_n == '0) begin
            has_a            = 1'b1;
            res_a.kind       = h3fd_pkg::KIND_EMPTY;
            res_a.frame_kind = type_q;
            res_a.frame_end  = 1'b1;
            phase_d          = PH_TYPE;
          end else begin
            phase_d = PH_PAY;
          end
        end else begin
          type_d  = acc_n;
          phase_d = PH_LEN;
        end
      end
    end

    if (end_i) begin
      ok         = (phase_d == PH_TYPE) && (vleft_d == '0);
      res_e.kind = ok ? h3fd_pkg::KIND_DONE : h3fd_pkg::KIND_ERROR;
      phase_d    = PH_TYPE;
      vleft_d    = '0;
      acc_d      = '0;
      type_d     = '0;
      left_d     = '0;
    end

    res_o = '0;
    if (has_a && end_i) begin
      res_o.num         = 2'd2;
      res_o.r0          = res_a;
      res_o.r1          = res_e;
      res_o.r1.run_last = 1'b1;
    end else if (has_a) begin
      res_o.num         = 2'd1;
      res_o.r0          = res_a;
      res_o.r0.run_last = 1'b1;
    end else if (end_i) begin
      res_o.num         = 2'd1;
      res_o.r0          = res_e;
      res_o.r0.run_last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TYPE;
      vleft_q <= '0;
      acc_q   <= '0;
      type_q  <= '0;
      left_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      vleft_q <= vleft_d;
      acc_q   <= acc_d;
      type_q  <= type_d;
      left_q  <= left_d;
    end
  end

  // no varint can be open while payload is being counted
  a_pay_no_varint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAY |-> vleft_q == '0)
    else $error("varint open during payload");

  // payload phase always has bytes still due
  a_pay_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAY |-> left_q != '0)
    else $error("payload phase with zero bytes left");

  // a buffer end always restores the idle parse state
  a_end_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && end_i |=> phase_q == PH_TYPE && vleft_q == '0 && type_q == '0)
    else $error("parser did not restart after buffer end");

endmodule

>>> rtl/core/h3fd_outq.sv
// Result queue: takes up to two results per cycle, hands out one beat per cycle while ready_i is high.
// Depends on h3fd_pkg.
`timescale 1ns / 1ps

module h3fd_outq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  h3fd_pkg::pres_t push_i,
  output logic            room_o,
  output logic            valid_o,
  input  logic            ready_i,
  output h3fd_pkg::res_t  res_o
);

  localparam int unsigned PtrW = $clog2(h3fd_pkg::QueueDepth);
  localparam int unsigned CntW = PtrW + 1;

  h3fd_pkg::res_t  mem_q [h3fd_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            pop;
  logic [PtrW-1:0] wr_ptr_p1;

  assign pop       = valid_o && ready_i;
  assign valid_o   = (cnt_q != '0);
  assign res_o     = mem_q[rd_ptr_q];
  // room for a two-result byte regardless of this cycle's pop
  assign room_o    = (cnt_q <= CntW'(h3fd_pkg::QueueDepth - 2));
  assign wr_ptr_p1 = wr_ptr_q + PtrW'(1);

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.r0;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wr_ptr_p1] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrW'(push_i.num);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      cnt_q <= cnt_q + CntW'(push_i.num) - CntW'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.num != 2'd0 |-> room_o)
    else $error("result queue overflow");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(h3fd_pkg::QueueDepth))
    else $error("result queue count out of range");

endmodule

>>> rtl/core/http3_frame_deframer_core.sv
// Top level of the HTTP/3 frame deframer: input beat register, parser, result queue.
// Depends on h3fd_pkg, h3fd_parse, h3fd_outq.
// Throughput: one input byte per cycle while the result queue has room; a byte that yields
// two results (payload or empty frame plus buffer end) is handed out one beat at a time.
// Reset: asynchronous, active low; clears the parse state and empties the result queue.
`timescale 1ns / 1ps

module http3_frame_deframer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tlast_i,   // buffer_end
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [71:0] m_axis_tdata_o,   // [61:0] frame_kind, [69:62] payload_byte, rest 0
  output logic [2:0]  m_axis_tuser_o,   // [1:0] kind, [2] run_last
  output logic        m_axis_tlast_o    // frame_end
);

  logic                       in_valid_q;
  logic [h3fd_pkg::ByteW-1:0] in_byte_q;
  logic                       in_end_q;
  logic                       room;
  logic                       step;
  h3fd_pkg::pres_t            pres;
  h3fd_pkg::res_t             res;

  assign step            = in_valid_q && room;
  assign s_axis_tready_o = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
      in_end_q  <= s_axis_tlast_i;
    end
  end

  h3fd_parse u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (in_byte_q),
    .end_i  (in_end_q),
    .res_o  (pres)
  );

  h3fd_pkg::pres_t push;
  always_comb begin
    push = pres;
    if (!step) begin
      push.num = 2'd0;
    end
  end

  h3fd_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .res_o   (res)
  );

  assign m_axis_tdata_o = {2'b00, res.payload_byte, res.frame_kind};
  assign m_axis_tuser_o = {res.run_last, res.kind};
  assign m_axis_tlast_o = res.frame_end;

  // a held input beat stays put until the parser takes it
  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !step |=> in_valid_q && $stable(in_byte_q) && $stable(in_end_q))
    else $error("stalled input beat lost");

endmodule

>>> bench/tb.sv
// Self-checking bench for http3_frame_deframer_core: byte stream in, tagged results out.
// Depends on h3fd_pkg and the core RTL; a scoreboard class predicts each result.
`timescale 1ns / 1ps

class deframe_scoreboard;
  typedef enum logic [1:0] {AWAIT_TYPE, AWAIT_LEN, IN_PAYLOAD} parse_phase_e;

  parse_phase_e          phase;
  logic [2:0]            vint_left;
  logic [61:0]           vint_acc;
  logic [61:0]           cur_type;
  logic [61:0]           body_left;
  h3fd_pkg::res_t        due_results[$];
  int unsigned           errors;

  function new();
    clear();
    errors = 0;
  endfunction

  function void clear();
    phase     = AWAIT_TYPE;
    vint_left = '0;
    vint_acc  = '0;
    cur_type  = '0;
    body_left = '0;
  endfunction

  function h3fd_pkg::res_t mk(h3fd_pkg::kind_e k, logic [61:0] fk, logic [7:0] pb, logic fe);
    h3fd_pkg::res_t r;
    r.kind         = k;
    r.frame_kind   = fk;
    r.payload_byte = pb;
    r.frame_end    = fe;
    r.run_last     = 1'b0;
    return r;
  endfunction

  // Parse one accepted byte and queue the results it should produce.
  function void note_byte(logic [7:0] b, logic last);
    h3fd_pkg::res_t rs[2];
    int             cnt;
    logic           fe;
    logic           ok;
    cnt = 0;
    if (phase == IN_PAYLOAD) begin
      body_left = body_left - 62'd1;
      fe = (body_left == '0);
      rs[cnt] = mk(h3fd_pkg::KIND_PAYLOAD, cur_type, b, fe);
      cnt++;
      if (fe) phase = AWAIT_TYPE;
    end else begin
      if (vint_left == '0) begin
        vint_acc  = {56'd0, b[5:0]};
        vint_left = 3'((4'd1 << b[7:6]) - 4'd1);
      end else begin
        vint_acc  = {vint_acc[53:0], b};
        vint_left = vint_left - 3'd1;
      end
      if (vint_left == '0) begin
        if (phase == AWAIT_LEN) begin
          body_left = vint_acc;
          if (body_left == '0) begin
            rs[cnt] = mk(h3fd_pkg::KIND_EMPTY, cur_type, 8'd0, 1'b1);
            cnt++;
            phase = AWAIT_TYPE;
          end else begin
            phase = IN_PAYLOAD;
          end
        end else begin
          cur_type = vint_acc;
          phase    = AWAIT_LEN;
        end
        vint_acc = '0;
      end
    end
    if (last) begin
      ok = (phase == AWAIT_TYPE) && (vint_left == '0);
      rs[cnt] = mk(ok ? h3fd_pkg::KIND_DONE : h3fd_pkg::KIND_ERROR, 62'd0, 8'd0, 1'b0);
      cnt++;
      clear();
    end
    if (cnt > 0) rs[cnt-1].run_last = 1'b1;
    for (int i = 0; i < cnt; i++) due_results.insert(due_results.size(), rs[i]);
  endfunction

  function void check_result(h3fd_pkg::res_t got);
    h3fd_pkg::res_t want;
    if (due_results.size() == 0) begin
      $display("%0t: unexpected result, kind %0d frame_kind %h", $time, got.kind,
               got.frame_kind);
      errors++;
      return;
    end
    want = due_results.pop_front();
    if (got.kind !== want.kind) begin
      $display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
      errors++;
    end
    if (got.frame_kind !== want.frame_kind) begin
      $display("%0t: frame_kind expected %h actual %h", $time, want.frame_kind,
               got.frame_kind);
      errors++;
    end
    if (got.payload_byte !== want.payload_byte) begin
      $display("%0t: payload_byte expected %h actual %h", $time, want.payload_byte,
               got.payload_byte);
      errors++;
    end
    if (got.frame_end !== want.frame_end) begin
      $display("%0t: frame_end expected %b actual %b", $time, want.frame_end, got.frame_end);
      errors++;
    end
    if (got.run_last !== want.run_last) begin
      $display("%0t: run_last expected %b actual %b", $time, want.run_last, got.run_last);
      errors++;
    end
  endfunction
endclass

module tb;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid;
  logic        s_ready;
  logic [7:0]  s_data;
  logic        s_last;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [71:0] m_data;
  logic [2:0]  m_user;
  logic        m_last;

  bit                calm;
  int unsigned       sent_bytes;
  logic [7:0]        frame_bytes[$];
  deframe_scoreboard sb;

  http3_frame_deframer_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user),
    .m_axis_tlast_o  (m_last)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    m_ready <= calm || ($urandom_range(99) >= 7);
  end

  always @(posedge clk_i) begin
    h3fd_pkg::res_t got;
    if (rst_ni && m_valid && m_ready) begin
      got.kind         = h3fd_pkg::kind_e'(m_user[1:0]);
      got.frame_kind   = m_data[61:0];
      got.payload_byte = m_data[69:62];
      got.frame_end    = m_last;
      got.run_last     = m_user[2];
      sb.check_result(got);
    end
  end

  task automatic send_beat(logic [7:0] d, logic l);
    while (!calm && $urandom_range(99) < 7) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= d;
    s_last  <= l;
    do @(posedge clk_i); while (!s_ready);
    sb.note_byte(d, l);
    sent_bytes++;
  endtask

  task automatic send_buffer();
    for (int i = 0; i < frame_bytes.size(); i++)
      send_beat(frame_bytes[i], i == frame_bytes.size() - 1);
    frame_bytes.delete();
  endtask

  // Hold the input off until every predicted result has been seen.
  task automatic drain_results();
    s_valid <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk_i);
  endtask

  // sz selects 1, 2, 4 or 8 bytes; v must fit in the remaining bits.
  task automatic put_varint(logic [61:0] v, int unsigned sz);
    logic [63:0] w;
    int          n;
    n = 1 << sz;
    w = {2'b00, v} | (64'(sz) << (8 * n - 2));
    for (int i = n - 1; i >= 0; i--) frame_bytes.insert(frame_bytes.size(), w[8*i +: 8]);
  endtask

  function automatic logic [61:0] rand_fit(int unsigned sz);
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return 62'(r >> (66 - (8 << sz)));
  endfunction

  task automatic random_buffer();
    int unsigned sz;
    int unsigned cut;
    logic [61:0] len;
    if ($urandom_range(99) < 5) begin
      // noise: arbitrary bytes, usually a truncated header or huge length
      repeat ($urandom_range(1, 8)) frame_bytes.insert(frame_bytes.size(), 8'($urandom()));
    end else begin
      repeat ($urandom_range(1, 4)) begin
        sz = $urandom_range(3);
        put_varint(rand_fit(sz), sz);
        len = ($urandom_range(3) == 0) ? 62'd0 : 62'($urandom_range(1, 6));
        put_varint(len, $urandom_range(3));
        repeat (len) frame_bytes.insert(frame_bytes.size(), 8'($urandom()));
      end
      if ($urandom_range(99) < 15 && frame_bytes.size() > 1) begin
        cut = $urandom_range(1, frame_bytes.size() - 1);
        while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
      end
    end
    send_buffer();
  endtask

  initial begin
    bit drained_mid;
    s_valid = 1'b0;
    s_data  = 8'd0;
    s_last  = 1'b0;
    calm    = 1'b0;
    drained_mid = 1'b0;
    sent_bytes  = 0;
    sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty frame on the buffer's last byte: two results from one beat
    put_varint(62'd0, 0);
    put_varint(62'd0, 0);
    send_buffer();
    // largest 8-byte type, one all-ones payload byte, clean end
    put_varint(62'h3FFF_FFFF_FFFF_FFFF, 3);
    put_varint(62'd1, 0);
    frame_bytes.insert(frame_bytes.size(), 8'hFF);
    send_buffer();
    // empty frame mid-buffer (2-byte zero length), then a 4-byte type
    put_varint(62'h21, 0);
    put_varint(62'd0, 1);
    put_varint(62'h3FFF_FFFF, 2);
    put_varint(62'd2, 0);
    frame_bytes.insert(frame_bytes.size(), 8'h00);
    frame_bytes.insert(frame_bytes.size(), 8'hAA);
    send_buffer();
    // cut inside a varint
    frame_bytes.insert(frame_bytes.size(), 8'h40);
    send_buffer();
    // cut between type and length
    frame_bytes.insert(frame_bytes.size(), 8'h05);
    send_buffer();
    // cut inside a payload
    put_varint(62'd1, 0);
    put_varint(62'd2, 0);
    frame_bytes.insert(frame_bytes.size(), 8'h33);
    send_buffer();
    drain_results();

    while (sent_bytes < 1300) begin
      calm = (sent_bytes >= 500 && sent_bytes < 800);
      if (!drained_mid && sent_bytes >= 900) begin
        drain_results();
        drained_mid = 1'b1;
      end
      random_buffer();
    end
    calm = 1'b0;
    drain_results();
    repeat (6) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
